### rtl/integer_iir_filter_macros.svh
// ----------------------------------------------------------------------------
// integer_iir_filter assertion macros
// concurrent check helpers shared by the filter rtl
// ----------------------------------------------------------------------------
`ifndef INTEGER_IIR_FILTER_MACROS_SVH
`define INTEGER_IIR_FILTER_MACROS_SVH

// consequent checked in the same cycle
`define IIRF_ASSERT_SAME(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// consequent checked in the following cycle
`define IIRF_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

### rtl/iirf_pkg.sv
// ----------------------------------------------------------------------------
// iirf_pkg
// widths, register indexes and shared types of the integer iir filter
// ----------------------------------------------------------------------------
package iirf_pkg;

   localparam int DATA_W      = 16;
   localparam int MAX_TAPS    = 4;
   localparam int DEF_TAPS    = 4;
   localparam int TAP_W       = $clog2(MAX_TAPS);
   localparam int HIST_D      = MAX_TAPS - 1;
   localparam int HIST_W      = $clog2(HIST_D);
   localparam int TERMS       = 2 * MAX_TAPS - 1;
   localparam int TERM_W      = $clog2(TERMS);
   localparam int DIGIT_W     = 4;
   localparam int DIGITS      = DATA_W / DIGIT_W;
   localparam int DIGIT_CNT_W = $clog2(DIGITS);
   localparam int SUM_W       = DATA_W + 1;
   localparam int DIV_CNT_W   = $clog2(SUM_W);
   localparam int CSR_IDX_W   = 3;

   localparam logic [CSR_IDX_W-1:0] CSR_B_COEFF_0 = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_B_COEFF_1 = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_B_COEFF_2 = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_B_COEFF_3 = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_A_COEFF_0 = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_A_COEFF_1 = 3'd5;
   localparam logic [CSR_IDX_W-1:0] CSR_A_COEFF_2 = 3'd6;
   localparam logic [CSR_IDX_W-1:0] CSR_A_COEFF_3 = 3'd7;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_MAC,
      ST_DIV,
      ST_DONE
   } state_type;

   typedef struct packed {
      logic              load;
      logic [TERM_W-1:0] sel;
      logic              done;
   } mac_stat_type;

endpackage

### rtl/iirf_mac.sv
// ----------------------------------------------------------------------------
// iirf_mac
// digit-serial multiply-accumulate over all taps, modulo 2^16
// ----------------------------------------------------------------------------
module iirf_mac (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           start,
   input  logic [iirf_pkg::DATA_W-1:0]    cand,
   input  logic [iirf_pkg::DATA_W-1:0]    plier,
   output iirf_pkg::mac_stat_type         stat,
   output logic [iirf_pkg::DATA_W-1:0]    acc
);

   logic                                busy_ff, busy_in;
   logic                                done_ff, done_in;
   logic [iirf_pkg::TERM_W-1:0]         term_ff, term_in;
   logic [iirf_pkg::DIGIT_CNT_W-1:0]    digit_ff, digit_in;
   logic [iirf_pkg::DATA_W-1:0]         cand_ff, cand_in;
   logic [iirf_pkg::DATA_W-1:0]         plier_ff, plier_in;
   logic [iirf_pkg::DATA_W-1:0]         acc_ff, acc_in;
   logic [iirf_pkg::DATA_W+iirf_pkg::DIGIT_W-1:0] part;
   logic                                last_digit;
   logic                                last_term;

   always_comb begin
      last_digit = (digit_ff == iirf_pkg::DIGIT_CNT_W'(iirf_pkg::DIGITS - 1));
      last_term  = (term_ff == iirf_pkg::TERM_W'(iirf_pkg::TERMS - 1));
      part       = {{iirf_pkg::DIGIT_W{1'b0}}, cand_ff}
                 * {{iirf_pkg::DATA_W{1'b0}}, plier_ff[iirf_pkg::DIGIT_W-1:0]};
      stat.load  = start || (busy_ff && last_digit && !last_term);
      stat.sel   = start ? '0 : iirf_pkg::TERM_W'(term_ff + 1'b1);
      stat.done  = done_ff;
      acc        = acc_ff;
   end

   always_comb begin
      busy_in  = busy_ff;
      done_in  = 1'b0;
      term_in  = term_ff;
      digit_in = digit_ff;
      cand_in  = cand_ff;
      plier_in = plier_ff;
      acc_in   = acc_ff;
      if (busy_ff) begin
         acc_in   = acc_ff + part[iirf_pkg::DATA_W-1:0];
         cand_in  = cand_ff << iirf_pkg::DIGIT_W;
         plier_in = plier_ff >> iirf_pkg::DIGIT_W;
         digit_in = iirf_pkg::DIGIT_CNT_W'(digit_ff + 1'b1);
         if (last_digit && last_term) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
      if (stat.load) begin
         cand_in  = cand;
         plier_in = plier;
         term_in  = stat.sel;
         digit_in = '0;
         busy_in  = 1'b1;
      end
      if (start) begin
         acc_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff  <= 1'b0;
         done_ff  <= 1'b0;
         term_ff  <= '0;
         digit_ff <= '0;
      end else begin
         busy_ff  <= busy_in;
         done_ff  <= done_in;
         term_ff  <= term_in;
         digit_ff <= digit_in;
      end
   end

   always_ff @(posedge clock) begin
      cand_ff  <= cand_in;
      plier_ff <= plier_in;
      acc_ff   <= acc_in;
   end

endmodule

### rtl/iirf_div.sv
// ----------------------------------------------------------------------------
// iirf_div
// bit-serial restoring divider, signed, truncating toward zero
// ----------------------------------------------------------------------------
module iirf_div (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   input  logic [iirf_pkg::SUM_W-1:0]    dividend,
   input  logic [iirf_pkg::DATA_W-1:0]   divisor,
   output logic                          done,
   output logic [iirf_pkg::DATA_W-1:0]   quotient
);

   logic                              busy_ff, busy_in;
   logic                              done_ff, done_in;
   logic                              neg_ff, neg_in;
   logic [iirf_pkg::DIV_CNT_W-1:0]    cnt_ff, cnt_in;
   logic [iirf_pkg::SUM_W-1:0]        rem_ff, rem_in;
   logic [iirf_pkg::SUM_W-1:0]        quo_ff, quo_in;
   logic [iirf_pkg::SUM_W-1:0]        dsr_ff, dsr_in;
   logic [iirf_pkg::SUM_W-1:0]        n_mag;
   logic [iirf_pkg::SUM_W-1:0]        d_mag;
   logic [iirf_pkg::SUM_W:0]          trial;
   logic [iirf_pkg::SUM_W:0]          diff;
   logic                              fits;
   logic [iirf_pkg::SUM_W-1:0]        signed_quo;

   always_comb begin
      n_mag = dividend[iirf_pkg::SUM_W-1] ? (~dividend + 1'b1) : dividend;
      d_mag = divisor[iirf_pkg::DATA_W-1]
            ? (~{divisor[iirf_pkg::DATA_W-1], divisor} + 1'b1)
            : {1'b0, divisor};
      trial = {rem_ff, quo_ff[iirf_pkg::SUM_W-1]};
      fits  = (trial >= {1'b0, dsr_ff});
      diff  = trial - {1'b0, dsr_ff};
      signed_quo = neg_ff ? (~quo_ff + 1'b1) : quo_ff;
      quotient   = signed_quo[iirf_pkg::DATA_W-1:0];
      done       = done_ff;
   end

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      neg_in  = neg_ff;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      dsr_in  = dsr_ff;
      if (start) begin
         busy_in = 1'b1;
         neg_in  = dividend[iirf_pkg::SUM_W-1] ^ divisor[iirf_pkg::DATA_W-1];
         cnt_in  = '0;
         rem_in  = '0;
         quo_in  = n_mag;
         dsr_in  = d_mag;
      end else if (busy_ff) begin
         rem_in = fits ? diff[iirf_pkg::SUM_W-1:0] : trial[iirf_pkg::SUM_W-1:0];
         quo_in = {quo_ff[iirf_pkg::SUM_W-2:0], fits};
         cnt_in = iirf_pkg::DIV_CNT_W'(cnt_ff + 1'b1);
         if (cnt_ff == iirf_pkg::DIV_CNT_W'(iirf_pkg::SUM_W - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      neg_ff <= neg_in;
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      dsr_ff <= dsr_in;
   end

endmodule

### rtl/integer_iir_filter.sv
// ----------------------------------------------------------------------------
// integer_iir_filter
// direct form i integer iir filter, four feed-forward and four feedback taps
//
// channel   direction  handshake               payload
// req       in         req_tvalid/req_tready   tdata sample_in, tuser frame_start
// rsp       out        rsp_tvalid/rsp_tready   tdata sample_out, tuser divide_error
// csr       in         csr_valid/csr_ready     csr_index, csr_data
//
// each sample runs through the 4-bit digit mac (7 terms x 4 digits), then the
// bit-serial divider; a zero a_coeff_0 skips the divider. one sample is in
// flight at a time; the result register lets the next sample start while the
// last result waits. reset is synchronous and restores coefficients and clears
// history. csr writes are always ready.
// ----------------------------------------------------------------------------
`include "integer_iir_filter_macros.svh"

module integer_iir_filter #(
   parameter int TAPS = iirf_pkg::DEF_TAPS
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_tvalid,
   output logic                              req_tready,
   input  logic [iirf_pkg::DATA_W-1:0]       req_tdata,  // sample_in
   input  logic                              req_tuser,  // frame_start
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   output logic [iirf_pkg::DATA_W-1:0]       rsp_tdata,  // sample_out
   output logic                              rsp_tuser,  // divide_error
   input  logic                              csr_valid,
   output logic                              csr_ready,
   input  logic [iirf_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [iirf_pkg::DATA_W-1:0]       csr_data
);

   iirf_pkg::state_type                 state_ff, state_in;
   logic                                start_ff, start_in;
   logic                                rsp_tvalid_ff, rsp_tvalid_in;
   logic [iirf_pkg::DATA_W-1:0]         rsp_data_ff, rsp_data_in;
   logic                                rsp_user_ff, rsp_user_in;
   logic [iirf_pkg::DATA_W-1:0]         b_ff [iirf_pkg::MAX_TAPS];
   logic [iirf_pkg::DATA_W-1:0]         b_in [iirf_pkg::MAX_TAPS];
   logic [iirf_pkg::DATA_W-1:0]         a_ff [iirf_pkg::MAX_TAPS];
   logic [iirf_pkg::DATA_W-1:0]         a_in [iirf_pkg::MAX_TAPS];
   logic [iirf_pkg::DATA_W-1:0]         xh_ff [iirf_pkg::HIST_D];
   logic [iirf_pkg::DATA_W-1:0]         xh_in [iirf_pkg::HIST_D];
   logic [iirf_pkg::DATA_W-1:0]         yh_ff [iirf_pkg::HIST_D];
   logic [iirf_pkg::DATA_W-1:0]         yh_in [iirf_pkg::HIST_D];
   logic [iirf_pkg::DATA_W-1:0]         x_ff, x_in;
   logic [iirf_pkg::DATA_W-1:0]         y_ff, y_in;
   logic                                err_ff, err_in;

   logic                                req_beat;
   logic                                a0_zero;
   logic                                div_start;
   logic                                y_load;
   logic                                y_err;
   logic                                out_load;
   iirf_pkg::mac_stat_type              mac_stat;
   logic [iirf_pkg::DATA_W-1:0]         mac_acc;
   logic [iirf_pkg::DATA_W-1:0]         cand_sel;
   logic [iirf_pkg::DATA_W-1:0]         plier_sel;
   logic [iirf_pkg::TAP_W-1:0]          tap_b;
   logic [iirf_pkg::TAP_W-1:0]          tap_a;
   logic [iirf_pkg::SUM_W-1:0]          half_sum;
   logic [iirf_pkg::SUM_W-1:0]          half;
   logic [iirf_pkg::SUM_W-1:0]          div_dividend;
   logic                                div_done;
   logic [iirf_pkg::DATA_W-1:0]         div_quo;

   assign csr_ready  = 1'b1;
   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_user_ff;
   assign req_beat   = req_tvalid && req_tready;
   assign a0_zero    = (a_ff[0] == '0);

   // term operands: b taps on x history, then negated a taps on y history
   always_comb begin
      cand_sel  = '0;
      plier_sel = '0;
      tap_b     = mac_stat.sel[iirf_pkg::TAP_W-1:0];
      tap_a     = iirf_pkg::TAP_W'(mac_stat.sel - iirf_pkg::TERM_W'(iirf_pkg::HIST_D));
      if (mac_stat.sel < iirf_pkg::TERM_W'(iirf_pkg::MAX_TAPS)) begin
         cand_sel  = (int'(tap_b) < TAPS) ? b_ff[tap_b] : '0;
         plier_sel = (tap_b == '0) ? x_ff
                                   : xh_ff[iirf_pkg::HIST_W'(tap_b - 1'b1)];
      end else begin
         cand_sel  = (int'(tap_a) < TAPS) ? ('0 - a_ff[tap_a]) : '0;
         plier_sel = yh_ff[iirf_pkg::HIST_W'(tap_a - 1'b1)];
      end
   end

   // acc + a0/2, a0/2 truncated toward zero
   always_comb begin
      half_sum = {a_ff[0][iirf_pkg::DATA_W-1], a_ff[0]}
               + {{iirf_pkg::DATA_W{1'b0}}, a_ff[0][iirf_pkg::DATA_W-1]};
      half     = {half_sum[iirf_pkg::SUM_W-1], half_sum[iirf_pkg::SUM_W-1:1]};
      div_dividend = {mac_acc[iirf_pkg::DATA_W-1], mac_acc} + half;
   end

   iirf_mac u_mac (
      .clock (clock),
      .reset (reset),
      .start (start_ff),
      .cand  (cand_sel),
      .plier (plier_sel),
      .stat  (mac_stat),
      .acc   (mac_acc)
   );

   iirf_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (div_dividend),
      .divisor  (a_ff[0]),
      .done     (div_done),
      .quotient (div_quo)
   );

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         iirf_pkg::ST_IDLE: begin
            if (req_beat) state_in = iirf_pkg::ST_MAC;
         end
         iirf_pkg::ST_MAC: begin
            if (mac_stat.done) begin
               state_in = a0_zero ? iirf_pkg::ST_DONE : iirf_pkg::ST_DIV;
            end
         end
         iirf_pkg::ST_DIV: begin
            if (div_done) state_in = iirf_pkg::ST_DONE;
         end
         iirf_pkg::ST_DONE: begin
            if (!rsp_tvalid_ff || rsp_tready) state_in = iirf_pkg::ST_IDLE;
         end
      endcase
   end

   always_comb begin
      req_tready = 1'b0;
      div_start  = 1'b0;
      y_load     = 1'b0;
      y_err      = 1'b0;
      out_load   = 1'b0;
      unique case (state_ff)
         iirf_pkg::ST_IDLE: begin
            req_tready = 1'b1;
         end
         iirf_pkg::ST_MAC: begin
            if (mac_stat.done) begin
               y_load    = a0_zero;
               y_err     = a0_zero;
               div_start = !a0_zero;
            end
         end
         iirf_pkg::ST_DIV: begin
            y_load = div_done;
         end
         iirf_pkg::ST_DONE: begin
            out_load = !rsp_tvalid_ff || rsp_tready;
         end
      endcase
   end

   always_comb begin
      b_in = b_ff;
      a_in = a_ff;
      if (csr_valid) begin
         unique case (csr_index)
            iirf_pkg::CSR_B_COEFF_0: b_in[0] = csr_data;
            iirf_pkg::CSR_B_COEFF_1: b_in[1] = csr_data;
            iirf_pkg::CSR_B_COEFF_2: b_in[2] = csr_data;
            iirf_pkg::CSR_B_COEFF_3: b_in[3] = csr_data;
            iirf_pkg::CSR_A_COEFF_0: a_in[0] = csr_data;
            iirf_pkg::CSR_A_COEFF_1: a_in[1] = csr_data;
            iirf_pkg::CSR_A_COEFF_2: a_in[2] = csr_data;
            iirf_pkg::CSR_A_COEFF_3: a_in[3] = csr_data;
         endcase
      end
   end

   always_comb begin
      start_in      = req_beat;
      x_in          = req_beat ? req_tdata : x_ff;
      y_in          = y_ff;
      err_in        = err_ff;
      xh_in         = xh_ff;
      yh_in         = yh_ff;
      rsp_data_in   = rsp_data_ff;
      rsp_user_in   = rsp_user_ff;
      rsp_tvalid_in = rsp_tvalid_ff && !rsp_tready;
      if (y_load) begin
         y_in   = y_err ? '0 : div_quo;
         err_in = y_err;
      end
      if (req_beat && req_tuser) begin
         for (int i = 0; i < iirf_pkg::HIST_D; i++) begin
            xh_in[i] = '0;
            yh_in[i] = '0;
         end
      end
      if (out_load) begin
         rsp_data_in   = y_ff;
         rsp_user_in   = err_ff;
         rsp_tvalid_in = 1'b1;
         xh_in[0]      = x_ff;
         yh_in[0]      = y_ff;
         for (int i = 1; i < iirf_pkg::HIST_D; i++) begin
            xh_in[i] = xh_ff[i-1];
            yh_in[i] = yh_ff[i-1];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= iirf_pkg::ST_IDLE;
         start_ff      <= 1'b0;
         rsp_tvalid_ff <= 1'b0;
         for (int i = 0; i < iirf_pkg::MAX_TAPS; i++) begin
            b_ff[i] <= (i == 0) ? iirf_pkg::DATA_W'(1) : '0;
            a_ff[i] <= (i == 0) ? iirf_pkg::DATA_W'(1) : '0;
         end
         for (int i = 0; i < iirf_pkg::HIST_D; i++) begin
            xh_ff[i] <= '0;
            yh_ff[i] <= '0;
         end
      end else begin
         state_ff      <= state_in;
         start_ff      <= start_in;
         rsp_tvalid_ff <= rsp_tvalid_in;
         b_ff          <= b_in;
         a_ff          <= a_in;
         xh_ff         <= xh_in;
         yh_ff         <= yh_in;
      end
   end

   always_ff @(posedge clock) begin
      x_ff        <= x_in;
      y_ff        <= y_in;
      err_ff      <= err_in;
      rsp_data_ff <= rsp_data_in;
      rsp_user_ff <= rsp_user_in;
   end

   `IIRF_ASSERT_NEXT(a_beat_starts_mac, clock, reset, req_beat,
      state_ff == iirf_pkg::ST_MAC && start_ff, "accepted beat did not start the mac")
   `IIRF_ASSERT_SAME(a_mac_done_in_mac, clock, reset, mac_stat.done,
      state_ff == iirf_pkg::ST_MAC, "mac finished outside the mac state")
   `IIRF_ASSERT_SAME(a_div_done_in_div, clock, reset, div_done,
      state_ff == iirf_pkg::ST_DIV, "divider finished outside the divide state")
   `IIRF_ASSERT_SAME(a_err_zero_out, clock, reset, rsp_tvalid && rsp_tuser,
      rsp_tdata == '0, "divide error beat carries nonzero data")

endmodule
